@@ rtl/tht_pkg.sv @@
`timescale 1ns / 1ps

package tht_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int JOBQ_DEPTH = 2;
    localparam int POS_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE = 1'b1;

    localparam logic [2:0] MODE_CHAR_BIN = 3'd0;
    localparam logic [2:0] MODE_CHAR_HEX = 3'd1;
    localparam logic [2:0] MODE_BIN_CHAR = 3'd2;
    localparam logic [2:0] MODE_BIN_HEX  = 3'd3;
    localparam logic [2:0] MODE_HEX_CHAR = 3'd4;
    localparam logic [2:0] MODE_HEX_BIN  = 3'd5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CTRL_MAX   = 8'd31;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;

    typedef enum logic [1:0] {
        JOB_RAW,
        JOB_BIN,
        JOB_HEX
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic       space;
    } job_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_dig_t;

    function automatic hex_dig_t hex_value(input logic [7:0] c);
        hex_dig_t r;
        r.ok  = 1'b0;
        r.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.ok = 1'b1;
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return CHAR_ZERO + {4'h0, n};
        end
        return CHAR_LOW_A + {4'h0, n} - 8'd10;
    endfunction

    // Number of characters one job emits.
    function automatic logic [POS_W-1:0] group_len(input job_t j);
        unique case (j.kind)
            JOB_RAW: return POS_W'(1);
            JOB_BIN: return POS_W'(8) + POS_W'(j.space);
            JOB_HEX: return POS_W'(2) + POS_W'(j.space);
            default: return POS_W'(1);
        endcase
    endfunction

    function automatic logic [7:0] char_at(input job_t j, input logic [POS_W-1:0] pos);
        logic [7:0] c;
        c = CHAR_SPACE;
        unique case (j.kind)
            JOB_RAW: c = j.data;
            JOB_BIN:
            begin
                if (!pos[3])
                begin
                    c = j.data[~pos[2:0]] ? CHAR_ONE : CHAR_ZERO;
                end
            end
            JOB_HEX:
            begin
                if (pos == POS_W'(0))
                begin
                    c = hex_char(j.data[7:4]);
                end
                else if (pos == POS_W'(1))
                begin
                    c = hex_char(j.data[3:0]);
                end
            end
            default: c = j.data;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/tht_front.sv @@
`timescale 1ns / 1ps

module tht_front (
    input  logic                clk,
    input  logic                rst_n,
    input  tht_pkg::cfg_write_t cfg,
    input  logic                in_valid,
    input  logic [7:0]          in_char,
    output logic                job_push,
    output tht_pkg::job_t       job
);
    import tht_pkg::*;

    logic [2:0] mode_reg;
    logic       space_reg;
    logic [2:0] count_reg, count_next;
    logic [7:0] partial_reg, partial_next;
    hex_dig_t   hv;
    logic [7:0] bin_shift;
    logic       is_bin_digit;

    assign hv           = hex_value(in_char);
    assign bin_shift    = {partial_reg[6:0], in_char[0]};
    assign is_bin_digit = (in_char == CHAR_ZERO) || (in_char == CHAR_ONE);

    always_comb
    begin
        count_next   = count_reg;
        partial_next = partial_reg;
        job_push     = 1'b0;
        job.kind     = JOB_RAW;
        job.data     = in_char;
        job.space    = space_reg;
        if (in_valid)
        begin
            unique case (mode_reg)
                MODE_CHAR_BIN, MODE_CHAR_HEX:
                begin
                    if (in_char > CTRL_MAX)
                    begin
                        job_push = 1'b1;
                        job.kind = (mode_reg == MODE_CHAR_BIN) ? JOB_BIN : JOB_HEX;
                    end
                end
                MODE_BIN_CHAR, MODE_BIN_HEX:
                begin
                    if (is_bin_digit)
                    begin
                        if (count_reg != 3'd7)
                        begin
                            count_next   = count_reg + 3'd1;
                            partial_next = bin_shift;
                        end
                        else
                        begin
                            count_next   = 3'd0;
                            partial_next = 8'd0;
                            job_push     = 1'b1;
                            job.data     = bin_shift;
                            job.kind     = (mode_reg == MODE_BIN_CHAR) ? JOB_RAW : JOB_HEX;
                        end
                    end
                end
                MODE_HEX_CHAR, MODE_HEX_BIN:
                begin
                    if (hv.ok)
                    begin
                        if (count_reg == 3'd0)
                        begin
                            count_next   = 3'd1;
                            partial_next = {4'h0, hv.val};
                        end
                        else
                        begin
                            count_next   = 3'd0;
                            partial_next = 8'd0;
                            job_push     = 1'b1;
                            job.data     = {partial_reg[3:0], hv.val};
                            job.kind     = (mode_reg == MODE_HEX_CHAR) ? JOB_RAW : JOB_BIN;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CHAR_BIN;
            space_reg   <= 1'b0;
            count_reg   <= 3'd0;
            partial_reg <= 8'd0;
        end
        else
        begin
            if (cfg.we && cfg.index == REG_MODE)
            begin
                // mode change drops any partly gathered group
                mode_reg    <= cfg.data;
                count_reg   <= 3'd0;
                partial_reg <= 8'd0;
            end
            else
            begin
                count_reg   <= count_next;
                partial_reg <= partial_next;
            end
            if (cfg.we && cfg.index == REG_SPACE)
            begin
                space_reg <= cfg.data[0];
            end
        end
    end

endmodule

@@ rtl/tht_jobq.sv @@
`timescale 1ns / 1ps

module tht_jobq #(
    parameter int DEPTH = tht_pkg::JOBQ_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tht_pkg::job_t job_in,
    input  logic          pop,
    output tht_pkg::job_t job_out,
    output logic          full,
    output logic          empty
);
    import tht_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == CNT_W'(0));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/tht_back.sv @@
`timescale 1ns / 1ps

module tht_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  tht_pkg::job_t q_head,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    out_char,
    output logic          last_of_group
);
    import tht_pkg::*;

    job_t             job_reg;
    logic             busy_reg;
    logic [POS_W-1:0] pos_reg;
    logic             out_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             taken, advance, at_last;

    assign taken   = pop && out_valid_reg;
    assign advance = busy_reg && (!out_valid_reg || taken);
    assign at_last = (pos_reg == group_len(job_reg) - POS_W'(1));
    // load the next request while the current one hands out its final character
    assign q_pop   = !q_empty && (!busy_reg || (advance && at_last));

    assign empty         = !out_valid_reg;
    assign out_char      = char_reg;
    assign last_of_group = last_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_head;
        end
        if (advance)
        begin
            char_reg <= char_at(job_reg, pos_reg);
            last_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end
            else if (advance)
            begin
                busy_reg <= !at_last;
                pos_reg  <= pos_reg + POS_W'(1);
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/text_hex_binary_transcoder.sv @@
`timescale 1ns / 1ps
// Character stream transcoder between raw text, binary digit text and hex digit text.
// Input side: present in_char with push; the request is taken on a clock edge where
// full is low. Output side: while empty is low, out_char and last_of_group show the
// oldest character; pop takes it. last_of_group marks the final character of one group.
// Configuration: cfg_we with cfg_index 0 (conversion mode) or 1 (space enable) and
// cfg_data; write only while the block is idle. A mode write drops a partial group.
// The first character of a request passes through the job queue, the job register and
// the output character register. The output side runs at one character per cycle while
// pop is high; a request emits 1 to 9 characters (raw 1, hex 2 or 3, binary 8 or 9).
// Non-producing or digit-gathering inputs are taken one per cycle while full is low.
// A job queue of JOBQ_DEPTH entries sits between classification and output; full
// rises when it holds that many pending groups, and a stalled pop holds everything
// still queued without loss.
// Reset clears the mode to character-to-binary, space off, gathered digits and all
// queues; empty is high and full low right after reset.

module text_hex_binary_transcoder #(
    parameter int JOBQ_DEPTH = tht_pkg::JOBQ_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tht_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     in_char,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     out_char,
    output logic                           last_of_group
);
    import tht_pkg::*;

    cfg_write_t cfg;
    job_t       job_new, job_head;
    logic       job_push, q_pop, q_empty, in_valid;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign in_valid  = push && !full;

    tht_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_char  (in_char),
        .job_push (job_push),
        .job      (job_new)
    );

    tht_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_new),
        .pop     (q_pop),
        .job_out (job_head),
        .full    (full),
        .empty   (q_empty)
    );

    tht_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (job_head),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .out_char      (out_char),
        .last_of_group (last_of_group)
    );

endmodule

@@ rtl/tht_checker.sv @@
`timescale 1ns / 1ps

module tht_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_char,
    input logic       last_of_group
);
    import tht_pkg::*;

    // reset leaves both sides open and nothing to read
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queue sides not idle during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_of_group)))
        else $error("stalled result changed");

    // a group continues without a gap once its earlier character is taken
    a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_group) |=> !empty)
        else $error("group broke off before its last character");

    // a space only ever closes a group
    a_space_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_of_group) |-> (out_char != CHAR_SPACE))
        else $error("space inside a group");

endmodule

bind text_hex_binary_transcoder tht_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .out_char      (out_char),
    .last_of_group (last_of_group)
);

@@ sim/tht_stream_checker.sv @@
`timescale 1ns / 1ps

module tht_stream_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tht_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  logic [7:0]                     in_char,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [7:0]                     out_char,
    input  logic                           last_of_group,
    output int                             errors,
    output int                             pending
);
    import tht_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_rec_t;

    out_rec_t   expected_chars[$];
    out_rec_t   head;
    logic [2:0] mode;
    logic       space_on;
    logic [2:0] digits_seen;
    logic [7:0] acc;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [7:0] hex_text(input logic [3:0] v);
        if (v > 4'd9)
        begin
            return 8'h61 + 8'(v - 4'd10);
        end
        return CHAR_ZERO + 8'(v);
    endfunction

    // {valid, value}
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= 8'h39)
        begin
            return {1'b1, 4'(c - CHAR_ZERO)};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'd0;
    endfunction

    task automatic predict_char(input logic [7:0] c);
        logic [7:0] grp [0:8];
        int         n;
        logic [4:0] hx;
        logic       done;
        logic [7:0] b;
        out_rec_t   rec;
        n    = 0;
        done = 1'b0;
        b    = 8'h00;
        case (mode)
            MODE_CHAR_BIN, MODE_CHAR_HEX:
            begin
                if (c > CTRL_MAX)
                begin
                    b    = c;
                    done = 1'b1;
                end
            end
            MODE_BIN_CHAR, MODE_BIN_HEX:
            begin
                if (c == CHAR_ZERO || c == CHAR_ONE)
                begin
                    acc = {acc[6:0], c == CHAR_ONE};
                    if (digits_seen == 3'd7)
                    begin
                        b           = acc;
                        done        = 1'b1;
                        digits_seen = 3'd0;
                        acc         = 8'h00;
                    end
                    else
                    begin
                        digits_seen = digits_seen + 3'd1;
                    end
                end
            end
            MODE_HEX_CHAR, MODE_HEX_BIN:
            begin
                hx = decode_hex(c);
                if (hx[4])
                begin
                    if (digits_seen == 3'd0)
                    begin
                        acc         = {4'h0, hx[3:0]};
                        digits_seen = 3'd1;
                    end
                    else
                    begin
                        b           = {acc[3:0], hx[3:0]};
                        done        = 1'b1;
                        digits_seen = 3'd0;
                        acc         = 8'h00;
                    end
                end
            end
            default:
            begin
                // unused modes ignore everything
            end
        endcase

        if (done)
        begin
            if (mode == MODE_BIN_CHAR || mode == MODE_HEX_CHAR)
            begin
                grp[0] = b;
                n      = 1;
            end
            else
            begin
                if (mode == MODE_CHAR_BIN || mode == MODE_HEX_BIN)
                begin
                    for (int i = 7; i >= 0; i--)
                    begin
                        grp[n] = b[i] ? CHAR_ONE : CHAR_ZERO;
                        n++;
                    end
                end
                else
                begin
                    grp[0] = hex_text(b[7:4]);
                    grp[1] = hex_text(b[3:0]);
                    n      = 2;
                end
                if (space_on)
                begin
                    grp[n] = CHAR_SPACE;
                    n++;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                rec.ch   = grp[i];
                rec.last = (i == n - 1);
                expected_chars.push_back(rec);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode        = MODE_CHAR_BIN;
            space_on    = 1'b0;
            digits_seen = 3'd0;
            acc         = 8'h00;
            expected_chars.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MODE)
                begin
                    // a mode write drops any partly gathered group
                    mode        = cfg_data[2:0];
                    digits_seen = 3'd0;
                    acc         = 8'h00;
                end
                else if (cfg_index == REG_SPACE)
                begin
                    space_on = cfg_data[0];
                end
            end

            if (push && !full)
            begin
                predict_char(in_char);
            end

            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char %h last %b",
                                              out_char, last_of_group));
                end
                else
                begin
                    head = expected_chars.pop_front();
                    if (out_char !== head.ch)
                    begin
                        report_mismatch($sformatf("out_char %h, wanted %h",
                                                  out_char, head.ch));
                    end
                    if (last_of_group !== head.last)
                    begin
                        report_mismatch($sformatf("last_of_group %b, wanted %b on char %h",
                                                  last_of_group, head.last, head.ch));
                    end
                end
            end

            pending <= expected_chars.size();
        end
    end

endmodule

@@ sim/tb_text_hex_binary_transcoder.sv @@
`timescale 1ns / 1ps

module tb_text_hex_binary_transcoder;
    import tht_pkg::*;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam int TARGET_ITEMS  = 410;
    localparam int SETTLE_CYCLES = 24;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  push      = 1'b0;
    logic [7:0]            in_char   = 8'h00;
    logic                  pop       = 1'b0;
    logic                  full;
    logic                  empty;
    logic [7:0]            out_char;
    logic                  last_of_group;

    int mismatches;
    int pending;
    int useful;
    int pop_hold;
    bit send_gaps;
    bit pop_gaps;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    text_hex_binary_transcoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .in_char       (in_char),
        .empty         (empty),
        .pop           (pop),
        .out_char      (out_char),
        .last_of_group (last_of_group)
    );

    tht_stream_checker stream_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .in_char       (in_char),
        .empty         (empty),
        .pop           (pop),
        .out_char      (out_char),
        .last_of_group (last_of_group),
        .errors        (mismatches),
        .pending       (pending)
    );

    // Output side: stall pop in random bursts.
    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else if (pop_gaps && $urandom_range(0, 7) == 0)
        begin
            pop_hold <= $urandom_range(0, 17);
            pop      <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    function automatic logic [7:0] nibble_text(input logic [3:0] v, input bit upper);
        if (v < 4'd10)
        begin
            return CHAR_ZERO + {4'h0, v};
        end
        return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    endfunction

    task automatic send_char(input logic [7:0] c);
        if (send_gaps && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push    <= 1'b1;
        in_char <= c;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    // Hold off until every expected char is out and the block has settled.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] m, input logic sp);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= CFG_DATA_W'(m);
        @(posedge clk);
        cfg_index <= REG_SPACE;
        cfg_data  <= CFG_DATA_W'(sp);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_bin_digits(input logic [7:0] b, input int len);
        for (int i = 7; i > 7 - len; i--)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_char(8'($urandom));
            end
            send_char(b[i] ? CHAR_ONE : CHAR_ZERO);
            useful++;
        end
    endtask

    task automatic send_hex_digits(input logic [7:0] b, input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_char(8'($urandom));
            end
            send_char(nibble_text(i == 0 ? b[7:4] : b[3:0], 1'($urandom)));
            useful++;
        end
    endtask

    task automatic run_phase(input logic [2:0] m, input int quota);
        logic [7:0] b;
        int         stop;
        stop = useful + quota;
        if (m == MODE_SPARE_6 || m == MODE_SPARE_7)
        begin
            repeat (quota / 4) send_char(8'($urandom));
        end
        else
        begin
            while (useful < stop)
            begin
                b = 8'($urandom);
                case (m)
                    MODE_CHAR_BIN, MODE_CHAR_HEX:
                    begin
                        send_char(b);
                        if (b > CTRL_MAX)
                        begin
                            useful++;
                        end
                    end
                    MODE_BIN_CHAR, MODE_BIN_HEX:
                    begin
                        // mostly whole groups, now and then a broken one
                        if ($urandom_range(0, 9) == 0)
                        begin
                            send_bin_digits(b, $urandom_range(1, 7));
                        end
                        else
                        begin
                            send_bin_digits(b, 8);
                        end
                    end
                    default:
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            send_hex_digits(b, 1);
                        end
                        else
                        begin
                            send_hex_digits(b, 2);
                        end
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [2:0] m;
        bit         tail;
        send_gaps = 1'b1;
        pop_gaps  = 1'b1;
        useful    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // control chars, first printable, top byte
        configure(MODE_CHAR_BIN, 1'b0);
        send_char(8'h00);
        send_char(8'h1F);
        send_char(8'h20);
        send_char(8'hFF);
        drain();
        configure(MODE_CHAR_HEX, 1'b1);
        send_char(8'h80);
        send_char(8'h7F);
        drain();
        // raw output never takes a space; a stray char is ignored mid-group
        configure(MODE_BIN_CHAR, 1'b1);
        send_char(CHAR_ONE);
        send_char("x");
        repeat (6) send_char(CHAR_ZERO);
        send_char(CHAR_ONE);
        drain();
        // partial group, dropped by the next mode write
        configure(MODE_BIN_HEX, 1'b0);
        send_char(CHAR_ONE);
        send_char(CHAR_ONE);
        drain();
        configure(MODE_HEX_CHAR, 1'b0);
        send_char("F");
        send_char("g");
        send_char("f");
        drain();
        configure(MODE_HEX_BIN, 1'b1);
        send_char("a");
        send_char(CHAR_ZERO);
        drain();
        configure(MODE_SPARE_6, 1'b1);
        send_char("A");
        send_char(CHAR_ZERO);
        drain();
        configure(MODE_SPARE_7, 1'b0);
        send_char(CHAR_ONE);
        drain();

        while (useful < TARGET_ITEMS)
        begin
            tail      = (useful >= TARGET_ITEMS - 60);
            send_gaps = !tail && $urandom_range(0, 3) != 0;
            pop_gaps <= !tail && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 7) == 0)
            begin
                m = $urandom_range(0, 1) ? MODE_SPARE_7 : MODE_SPARE_6;
            end
            else
            begin
                m = 3'($urandom_range(0, 5));
            end
            configure(m, 1'($urandom));
            run_phase(m, $urandom_range(16, 40));
            drain();
        end

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
